FILE: design/wcts_pkg.sv
// ----------------------------------------------------------------------------
// Windowed coarse time sorter package
// Shared types and constants for the sorter front end, queue and sort store.
// ----------------------------------------------------------------------------
package wcts_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned TagW  = 32;
  localparam int unsigned CntW  = 32;

  // classified transaction handed from the front end to the sort store
  typedef struct packed {
    logic             keep;
    logic             last;
    logic [TimeW-1:0] key;
    logic [TimeW-1:0] hit_time;
    logic [TagW-1:0]  hit_tag;
  } wcts_cmd_t;

endpackage

FILE: design/wcts_front.sv
// ----------------------------------------------------------------------------
// Sorter front end
// Window test and coarse key: key = time / bin width by reciprocal multiply
// in three 16-bit partial products with a final correction.
// ----------------------------------------------------------------------------
module wcts_front #(
  parameter int unsigned BinWidthPs = 25000
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [wcts_pkg::TimeW-1:0] hit_time_i,
  input  logic [wcts_pkg::TagW-1:0]  hit_tag_i,
  input  logic [wcts_pkg::TimeW-1:0] window_start_i,
  input  logic [wcts_pkg::TimeW-1:0] window_end_i,
  input  logic                      batch_last_i,
  output logic                      cmd_valid_o,
  output wcts_pkg::wcts_cmd_t       cmd_o,
  input  logic                      cmd_ready_i
);
  import wcts_pkg::*;

  // key estimate: floor(t * M / 2^64) with M = floor((2^64 - 1) / B); off by at most 1
  localparam logic [63:0] RecipL = 64'hFFFF_FFFF_FFFF_FFFF / 64'(BinWidthPs);
  // remainder stays below twice the bin width, so its low bits suffice
  localparam int unsigned     RemW = 22;
  localparam logic [RemW-1:0] BinR = RemW'(BinWidthPs);

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StMulLo = 4'b0010, StMulHi = 4'b0100, StOut = 4'b1000
  } st_e;

  st_e st_q, st_d;
  logic [TimeW-1:0] t_q;
  logic [TagW-1:0]  tag_q;
  logic             keep_q, last_q;
  logic [1:0]       part_q;
  logic [111:0]     acc_q;
  logic [TimeW-1:0] est;
  logic [RemW-1:0]  rem;
  logic [TimeW+31:0] pp;
  logic [15:0]      tsel;

  assign busy_o = (st_q != StIdle);
  assign tsel   = t_q[16*part_q +: 16];
  assign pp     = RecipL * tsel;  // 64 x 16 per cycle

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      t_q    <= hit_time_i;
      tag_q  <= hit_tag_i;
      keep_q <= (hit_time_i >= window_start_i) && (hit_time_i < window_end_i);
      last_q <= batch_last_i;
      acc_q  <= '0;
    end else if (st_q == StMulLo || st_q == StMulHi) begin
      acc_q  <= acc_q + ({32'd0, pp} << (16*part_q));
    end
  end

  assign est = acc_q[64 +: TimeW];
  assign rem = t_q[RemW-1:0] - est[RemW-1:0] * BinR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      part_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StIdle) part_q <= '0;
      else if (st_q == StMulLo || st_q == StMulHi) part_q <= part_q + 2'd1;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (start_i) st_d = StMulLo;
      StMulLo: if (part_q == 2'd1) st_d = StMulHi;
      StMulHi: st_d = StOut;
      StOut:   if (cmd_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign cmd_valid_o    = (st_q == StOut);
  assign cmd_o.keep     = keep_q;
  assign cmd_o.last     = last_q;
  assign cmd_o.key      = (rem >= BinR) ? est + TimeW'(1) : est;
  assign cmd_o.hit_time = t_q;
  assign cmd_o.hit_tag  = tag_q;

  ap_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("front not busy after accept");
  ap_out_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_valid_o) |-> $past(st_q == StMulHi)) else $error("command skipped multiply");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && !cmd_ready_i) |=> cmd_valid_o) else $error("command dropped");
endmodule

FILE: design/wcts_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between front end and sort store.
// ----------------------------------------------------------------------------
module wcts_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcts_pkg::wcts_cmd_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcts_pkg::wcts_cmd_t out_o
);
  import wcts_pkg::*;

  wcts_cmd_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  ap_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  ap_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("queue pointers");
  ap_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
endmodule

FILE: design/wcts_store.sv
// ----------------------------------------------------------------------------
// Sort store
// Insertion chain of cells held sorted by key; shifts one slot per insert,
// then streams the run out one result per cycle on the batch's last item.
// ----------------------------------------------------------------------------
module wcts_store #(
  parameter int unsigned Capacity = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wcts_pkg::wcts_cmd_t       cmd_i,
  output logic                      done_o,
  output logic [wcts_pkg::TimeW-1:0] out_time_o,
  output logic [wcts_pkg::TagW-1:0]  out_tag_o,
  output logic                      out_last_o,
  output logic                      batch_empty_o,
  output logic                      batch_overflow_o,
  output logic [wcts_pkg::CntW-1:0]  passed_count_o
);
  import wcts_pkg::*;

  localparam int unsigned FillW = $clog2(Capacity + 1);

  typedef enum logic [1:0] { StIn = 2'b01, StEmit = 2'b10 } st_e;

  st_e st_q;
  logic [TimeW-1:0] key_q  [Capacity];
  logic [TimeW-1:0] time_q [Capacity];
  logic [TagW-1:0]  tag_q  [Capacity];
  logic [FillW-1:0] fill_q;
  logic             ovf_q;
  logic [CntW-1:0]  total_q;
  logic             take, ins, full;
  logic [Capacity-1:0] gt;

  assign cmd_ready_o = (st_q == StIn);
  assign take = cmd_valid_i && cmd_ready_o;
  assign full = (fill_q == FillW'(Capacity));
  assign ins  = take && cmd_i.keep && !full;

  // a cell moves up when it is occupied and its key exceeds the new one
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      gt[i] = (FillW'(i) < fill_q) && (key_q[i] > cmd_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) begin
      for (int i = 0; i < Capacity; i++) begin
        if (gt[i] && i + 1 < Capacity) begin
          key_q[(i+1) % Capacity]  <= key_q[i];
          time_q[(i+1) % Capacity] <= time_q[i];
          tag_q[(i+1) % Capacity]  <= tag_q[i];
        end
        if ((i == 0 || !gt[(i+Capacity-1) % Capacity]) &&
            (gt[i] || FillW'(i) == fill_q)) begin
          key_q[i]  <= cmd_i.key;
          time_q[i] <= cmd_i.hit_time;
          tag_q[i]  <= cmd_i.hit_tag;
        end
      end
    end else if (st_q == StEmit) begin
      for (int i = 0; i + 1 < Capacity; i++) begin
        time_q[i] <= time_q[i+1];
        tag_q[i]  <= tag_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIn;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      total_q <= '0;
      done_o  <= 1'b0;
      out_last_o       <= 1'b0;
      batch_empty_o    <= 1'b0;
      batch_overflow_o <= 1'b0;
      passed_count_o   <= '0;
      out_time_o       <= '0;
      out_tag_o        <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        StIn: begin
          if (take) begin
            if (ins) fill_q <= fill_q + FillW'(1);
            if (cmd_i.keep && full) ovf_q <= 1'b1;
            if (cmd_i.last) begin
              if (fill_q == '0 && !ins) begin
                done_o           <= 1'b1;
                out_time_o       <= '0;
                out_tag_o        <= '0;
                out_last_o       <= 1'b1;
                batch_empty_o    <= 1'b1;
                batch_overflow_o <= ovf_q;
                passed_count_o   <= total_q;
                ovf_q            <= 1'b0;
              end else begin
                st_q <= StEmit;
              end
            end
          end
        end
        StEmit: begin
          done_o           <= 1'b1;
          out_time_o       <= time_q[0];
          out_tag_o        <= tag_q[0];
          out_last_o       <= (fill_q == FillW'(1));
          batch_empty_o    <= 1'b0;
          batch_overflow_o <= ovf_q;
          passed_count_o   <= total_q + CntW'(1);
          total_q          <= total_q + CntW'(1);
          fill_q           <= fill_q - FillW'(1);
          if (fill_q == FillW'(1)) begin
            st_q  <= StIn;
            ovf_q <= 1'b0;
          end
        end
        default: st_q <= StIn;
      endcase
    end
  end

  ap_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Capacity)) else $error("fill count beyond capacity");
  ap_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StEmit) |-> (fill_q != '0)) else $error("emission with empty store");
  ap_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o && done_o |=> !done_o || st_q == StIn) else $error("run overran");
endmodule

FILE: design/windowed_coarse_time_sorter_unit.sv
// ----------------------------------------------------------------------------
// Windowed coarse time sorter
// Stable insertion sort of detector hits by time bin, emitted per batch.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// hit      in         start / busy         hit_time_i hit_tag_i window_*_i batch_last_i
// result   out        done strobe          out_*_o batch_*_o passed_count_o
//
// The front end takes one hit at a time (window test, three-step key
// multiply); the sort store inserts one hit per cycle through its cell chain.
// On the batch's last hit the store streams one result per cycle and takes no
// hit meanwhile; the queue between the parts holds up to two hits.
// Reset clears all control state; the store needs no clearing pass.
// The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
module windowed_coarse_time_sorter_unit #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned BIN_WIDTH_PS = 25000
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [wcts_pkg::TimeW-1:0] hit_time_i,
  input  logic [wcts_pkg::TagW-1:0]  hit_tag_i,
  input  logic [wcts_pkg::TimeW-1:0] window_start_i,
  input  logic [wcts_pkg::TimeW-1:0] window_end_i,
  input  logic                      batch_last_i,
  output logic                      done,
  output logic [wcts_pkg::TimeW-1:0] out_time_o,
  output logic [wcts_pkg::TagW-1:0]  out_tag_o,
  output logic                      out_last_o,
  output logic                      batch_empty_o,
  output logic                      batch_overflow_o,
  output logic [wcts_pkg::CntW-1:0]  passed_count_o
);
  import wcts_pkg::*;

  logic      f_valid, f_ready, q_valid, q_ready;
  wcts_cmd_t f_cmd, q_cmd;

  wcts_front #(.BinWidthPs(BIN_WIDTH_PS)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .hit_time_i, .hit_tag_i, .window_start_i, .window_end_i, .batch_last_i,
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_ready_i(f_ready)
  );

  wcts_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_i(f_cmd),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_o(q_cmd)
  );

  wcts_store #(.Capacity(CAPACITY)) u_store (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .done_o(done), .out_time_o, .out_tag_o, .out_last_o, .batch_empty_o,
    .batch_overflow_o, .passed_count_o
  );
endmodule

FILE: verif/wcts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed coarse time sorter checker
// Watches the hit and result channels, keeps its own sorted hit store per
// batch and compares every emitted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module wcts_checker #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned BIN_WIDTH_PS = 25000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [wcts_pkg::TimeW-1:0] hit_time_i,
  input  logic [wcts_pkg::TagW-1:0]  hit_tag_i,
  input  logic [wcts_pkg::TimeW-1:0] window_start_i,
  input  logic [wcts_pkg::TimeW-1:0] window_end_i,
  input  logic                       batch_last_i,
  input  logic                       done,
  input  logic [wcts_pkg::TimeW-1:0] out_time_i,
  input  logic [wcts_pkg::TagW-1:0]  out_tag_i,
  input  logic                       out_last_i,
  input  logic                       batch_empty_i,
  input  logic                       batch_overflow_i,
  input  logic [wcts_pkg::CntW-1:0]  passed_count_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_seen_o,
  output int                         overflow_batches_o
);
  import wcts_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0] hit_time;
    logic [TagW-1:0]  hit_tag;
    logic             last;
    logic             empty;
    logic             overflow;
    logic [CntW-1:0]  passed;
  } sorted_hit_t;

  logic [TimeW-1:0] bin_store [CAPACITY];
  logic [TimeW-1:0] time_store [CAPACITY];
  logic [TagW-1:0]  tag_store [CAPACITY];
  int unsigned      stored;
  logic             dropped_full;
  logic [CntW-1:0]  emitted_total;
  sorted_hit_t      sorted_out_q[$];

  assign pending_o = sorted_out_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic queue_result(input sorted_hit_t r);
    sorted_out_q = {sorted_out_q, r};
  endtask

  task automatic sort_hit(input logic [TimeW-1:0] t, input logic [TagW-1:0] tag,
                          input logic [TimeW-1:0] ws, input logic [TimeW-1:0] we,
                          input logic last);
    logic [TimeW-1:0] bin;
    int unsigned      pos;
    sorted_hit_t      r;
    if (t >= ws && t < we) begin
      bin = t / BIN_WIDTH_PS;
      if (stored >= CAPACITY) begin
        dropped_full = 1'b1;
      end else begin
        pos = stored;
        while (pos > 0 && bin_store[pos-1] > bin) begin
          bin_store[pos]  = bin_store[pos-1];
          time_store[pos] = time_store[pos-1];
          tag_store[pos]  = tag_store[pos-1];
          pos--;
        end
        bin_store[pos]  = bin;
        time_store[pos] = t;
        tag_store[pos]  = tag;
        stored++;
      end
    end
    if (last) begin
      if (dropped_full) overflow_batches_o++;
      if (stored == 0) begin
        r = '{hit_time: '0, hit_tag: '0, last: 1'b1, empty: 1'b1,
              overflow: dropped_full, passed: emitted_total};
        queue_result(r);
      end else begin
        for (int unsigned i = 0; i < stored; i++) begin
          emitted_total++;
          r = '{hit_time: time_store[i], hit_tag: tag_store[i], last: (i + 1 == stored),
                empty: 1'b0, overflow: dropped_full, passed: emitted_total};
          queue_result(r);
        end
      end
      stored       = 0;
      dropped_full = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_hit_t want;
    if (!rst_ni) begin
      stored        = 0;
      dropped_full  = 1'b0;
      emitted_total = '0;
      sorted_out_q.delete();
    end else begin
      if (done) begin
        results_seen_o++;
        if (sorted_out_q.size() == 0) begin
          report_mismatch("unexpected result", out_tag_i, 0);
        end else begin
          want = sorted_out_q.pop_front();
          if (out_time_i !== want.hit_time)
            report_mismatch("out_time", out_time_i, want.hit_time);
          if (out_tag_i !== want.hit_tag)
            report_mismatch("out_tag", out_tag_i, want.hit_tag);
          if (out_last_i !== want.last)
            report_mismatch("out_last", out_last_i, want.last);
          if (batch_empty_i !== want.empty)
            report_mismatch("batch_empty", batch_empty_i, want.empty);
          if (batch_overflow_i !== want.overflow)
            report_mismatch("batch_overflow", batch_overflow_i, want.overflow);
          if (passed_count_i !== want.passed)
            report_mismatch("passed_count", passed_count_i, want.passed);
        end
      end
      if (start && !busy)
        sort_hit(hit_time_i, hit_tag_i, window_start_i, window_end_i, batch_last_i);
    end
  end

  initial begin
    fail_count_o       = 0;
    results_seen_o     = 0;
    overflow_batches_o = 0;
  end
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed coarse time sorter testbench
// Drives hit batches (directed edge cases, then random batches with random
// gaps) into the sorter; the checker predicts and compares the sorted output.
// ----------------------------------------------------------------------------
module testbench;
  import wcts_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned BIN_WIDTH_PS = 25000;
  localparam logic [TimeW-1:0] TimeMax = '1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [TimeW-1:0] hit_time_i = '0;
  logic [TagW-1:0]  hit_tag_i = '0;
  logic [TimeW-1:0] window_start_i = '0;
  logic [TimeW-1:0] window_end_i = '0;
  logic             batch_last_i = 1'b0;
  logic             done;
  logic [TimeW-1:0] out_time_o;
  logic [TagW-1:0]  out_tag_o;
  logic             out_last_o;
  logic             batch_empty_o;
  logic             batch_overflow_o;
  logic [CntW-1:0]  passed_count_o;
  int               fail_count, pending, results_seen, overflow_batches;
  int               idle_pct, hits_sent, batches_sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  windowed_coarse_time_sorter_unit #(
    .CAPACITY(CAPACITY), .BIN_WIDTH_PS(BIN_WIDTH_PS)
  ) dut (.*);

  wcts_checker #(.CAPACITY(CAPACITY), .BIN_WIDTH_PS(BIN_WIDTH_PS)) u_checker (
    .clk_i, .rst_ni, .start, .busy, .hit_time_i, .hit_tag_i, .window_start_i,
    .window_end_i, .batch_last_i, .done, .out_time_i(out_time_o),
    .out_tag_i(out_tag_o), .out_last_i(out_last_o), .batch_empty_i(batch_empty_o),
    .batch_overflow_i(batch_overflow_o), .passed_count_i(passed_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen),
    .overflow_batches_o(overflow_batches)
  );

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom, $urandom});
  endfunction

  task automatic send_hit(input logic [TimeW-1:0] t, input logic [TagW-1:0] tag,
                          input logic [TimeW-1:0] ws, input logic [TimeW-1:0] we,
                          input logic last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    hit_time_i     <= t;
    hit_tag_i      <= tag;
    window_start_i <= ws;
    window_end_i   <= we;
    batch_last_i   <= last;
    start          <= 1'b1;
    @(posedge clk_i iff !busy);
    hits_sent++;
    if (last) batches_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_batch(input int n);
    logic [TimeW-1:0] ws, we, span, t;
    int               mode;
    mode = $urandom_range(9);
    span = BIN_WIDTH_PS * $urandom_range(12, 1);
    ws   = (mode == 0) ? TimeMax - span - 1000 : rand_time() >> $urandom_range(24);
    we   = (mode == 1) ? ws - $urandom_range(1) : ws + span;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: t = ws - $urandom_range(3, 1);
        1: t = we + $urandom_range(2) - 1;
        2: t = rand_time();
        default: t = ws + $urandom_range(32'(span - 1));
      endcase
      if ($urandom_range(19) == 0) begin
        ws = rand_time();
        we = rand_time();
      end
      send_hit(t, $urandom, ws, we, i == n - 1);
    end
  endtask

  initial begin
    idle_pct = 27;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty batch, window bounds, inverted window, extremes
    send_hit(48'd5, 32'h0, 48'd10, 48'd20, 1'b1);
    send_hit(48'd100, 32'hffffffff, 48'd100, 48'd200, 1'b0);
    send_hit(48'd200, 32'h1, 48'd100, 48'd200, 1'b0);
    send_hit(48'd199, 32'h2, 48'd100, 48'd200, 1'b0);
    send_hit(48'd0, 32'h3, 48'd0, 48'd1, 1'b0);
    send_hit(48'd50, 32'h4, 48'd60, 48'd40, 1'b0);
    send_hit(48'd50, 32'h5, 48'd50, 48'd50, 1'b0);
    send_hit(TimeMax, 32'h6, 48'd0, TimeMax, 1'b0);
    send_hit(TimeMax - 1, 32'haaaaaaaa, 48'd0, TimeMax, 1'b1);
    // equal bins keep arrival order; last hit itself dropped
    send_hit(48'd75000, 32'h10, 48'd0, 48'd1000000, 1'b0);
    send_hit(48'd99999, 32'h11, 48'd0, 48'd1000000, 1'b0);
    send_hit(48'd80000, 32'h12, 48'd0, 48'd1000000, 1'b0);
    send_hit(48'd24999, 32'h13, 48'd0, 48'd1000000, 1'b0);
    send_hit(48'd25000, 32'h14, 48'd0, 48'd1000000, 1'b0);
    send_hit(48'd2000000, 32'h15, 48'd0, 48'd1000000, 1'b1);
    send_hit(48'd30, 32'h16, 48'd0, 48'd1000000, 1'b1);
    drain_results();

    while (hits_sent < 320) begin
      if (hits_sent > 130) idle_pct = 62;
      if (hits_sent > 240) idle_pct = 0;
      case ($urandom_range(14))
        0: send_batch($urandom_range(70, 62));
        1: send_batch(1);
        default: send_batch($urandom_range(10, 2));
      endcase
      if ($urandom_range(7) == 0) drain_results();
    end
    drain_results();
    repeat (40) @(posedge clk_i);

    $display("covered %0d hits in %0d batches, %0d results, %0d overflowing batches",
             hits_sent, batches_sent, results_seen, overflow_batches);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: sim.f
design/wcts_pkg.sv
design/wcts_front.sv
design/wcts_queue.sv
design/wcts_store.sv
design/windowed_coarse_time_sorter_unit.sv
verif/wcts_checker.sv
verif/testbench.sv
